/* design/circular_deque_assert.svh */
// ----------------------------------------------------------------------------
// circular_deque_assert: assertion macros used by the deque checker
// Concurrent property wrappers with a clock, a reset and an error message.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while rst_n is low
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg: shared constants for the circular deque
// Operation codes, field widths, register map and result word layout.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    localparam int FUNC_W = 3;
    localparam logic [FUNC_W-1:0] F_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] F_PUSH_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] F_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] F_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] F_QUERY      = 3'd4;

    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

    localparam int S_TDATA_W = 32;
    localparam int OUT_W     = 32;

    localparam int M_OK_BIT    = 0;
    localparam int M_FRONT_LSB = 1;
    localparam int M_REAR_LSB  = M_FRONT_LSB + OUT_W;
    localparam int M_EMPTY_BIT = M_REAR_LSB + OUT_W;
    localparam int M_FULL_BIT  = M_EMPTY_BIT + 1;
    localparam int M_TDATA_W   = 72;
    localparam int M_PAD_W     = M_TDATA_W - M_FULL_BIT - 1;

endpackage

/* design/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue held in a ring memory
// Push and pop at either end, with a query, over a stream in and a stream out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tuser carries the operation (push front, push rear,
//   pop front, pop rear, query), s_axis_tdata the value to push. Each
//   transaction gives exactly one result transaction on m_axis: ok flag,
//   front and rear values after the operation (all ones when empty), and
//   the empty and full flags.
//   A result is registered in the cycle after acceptance; a pop that leaves
//   entries behind first reads the new end value from the ring memory into
//   a read register. Throughput is one item per cycle for pushes, queries and
//   refused operations while no result stalls; such pops block input meanwhile.
//   The capacity register (APB, byte address 0) saturates to 1..DEPTH; any
//   write empties the deque. Write it only while no transaction is pending.
//   Reset empties the deque, sets capacity to min(DEPTH, 16) and drops any
//   pending result. While m_axis_tready is low the result holds and no new
//   transaction is taken until the output slot frees.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] data_value
    input  logic [FUNC_W-1:0]     s_axis_tuser,   // [2:0] func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] ok, [32:1] front_value, [64:33] rear_value, [65] is_empty,
    // [66] is_full, [71:67] zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
    localparam logic [CAP_W-1:0] CAP_INIT = CAP_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);
    localparam logic [DATA_WIDTH-1:0] EMPTY_VAL = '1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(i) + CMP_W'(1);
        return (nxt >= CMP_W'(cap)) ? '0 : IDX_W'(nxt);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
        return (i == '0) ? IDX_W'(cap - CAP_W'(1)) : i - IDX_W'(1);
    endfunction

    function automatic logic [OUT_W-1:0] out_val(input logic empty,
                                                 input logic [DATA_WIDTH-1:0] v);
        return OUT_W'(empty ? EMPTY_VAL : v);
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic                  r_state;
    logic [CAP_W-1:0]      r_cap;
    logic [IDX_W-1:0]      r_head, r_tail;
    logic                  r_empty;
    logic [DATA_WIDTH-1:0] r_front, r_rear;
    logic                  r_pop_front;

    logic                  r_out_valid;
    logic                  r_ok, r_out_empty, r_out_full;
    logic [OUT_W-1:0]      r_out_front, r_out_rear;

    logic [IDX_W-1:0]      n_head, n_tail;
    logic                  n_empty;
    logic [DATA_WIDTH-1:0] n_front, n_rear;
    logic                  n_ok, n_need_rd, n_pop_front;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] w_val, w_rd_front, w_rd_rear;
    logic                  w_acc, w_cfg_wr, w_full, w_n_full;
    logic [CAP_W-1:0]      w_cap_raw, w_cap_sat;

    assign w_val         = DATA_WIDTH'(s_axis_tdata);
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_full        = !r_empty && (idx_inc(r_tail, r_cap) == r_head);
    assign w_n_full      = !n_empty && (idx_inc(n_tail, r_cap) == n_head);

    assign pready   = 1'b1;
    assign prdata   = APB_DATA_W'(r_cap);
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
    assign w_cap_raw = pwdata[CAP_W-1:0];

    always_comb begin
        if (w_cap_raw == '0) begin
            w_cap_sat = CAP_W'(1);
        end else if (32'(w_cap_raw) > 32'(DEPTH)) begin
            w_cap_sat = CAP_W'(DEPTH);
        end else begin
            w_cap_sat = w_cap_raw;
        end
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_front     = r_front;
        n_rear      = r_rear;
        n_ok        = 1'b1;
        n_need_rd   = 1'b0;
        n_pop_front = 1'b0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_raddr     = '0;
        case (s_axis_tuser) inside
            F_PUSH_FRONT, F_PUSH_REAR: begin
                if (w_full) begin
                    n_ok = 1'b0;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    n_front = w_val;
                    n_rear  = w_val;
                    w_we    = 1'b1;
                end else if (s_axis_tuser == F_PUSH_FRONT) begin
                    n_head  = idx_dec(r_head, r_cap);
                    n_front = w_val;
                    w_we    = 1'b1;
                    w_waddr = n_head;
                end else begin
                    n_tail  = idx_inc(r_tail, r_cap);
                    n_rear  = w_val;
                    w_we    = 1'b1;
                    w_waddr = n_tail;
                end
            end
            F_POP_FRONT, F_POP_REAR: begin
                if (r_empty) begin
                    n_ok = 1'b0;
                end else if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (s_axis_tuser == F_POP_FRONT) begin
                    n_head      = idx_inc(r_head, r_cap);
                    w_raddr     = n_head;
                    n_need_rd   = 1'b1;
                    n_pop_front = 1'b1;
                end else begin
                    n_tail    = idx_dec(r_tail, r_cap);
                    w_raddr   = n_tail;
                    n_need_rd = 1'b1;
                end
            end
            F_QUERY: begin
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign w_rd_front = r_pop_front ? r_rd_data : r_front;
    assign w_rd_rear  = r_pop_front ? r_rear : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_acc && w_we) begin
            mem[w_waddr] <= w_val;
        end
        r_rd_data <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_INIT;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_cap   <= w_cap_sat;
                r_head  <= '0;
                r_tail  <= '0;
                r_empty <= 1'b1;
            end else if (w_acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_empty <= n_empty;
            end
            if (w_acc) begin
                r_state <= n_need_rd ? ST_READ : ST_IDLE;
            end else if (r_state == ST_READ) begin
                r_state <= ST_IDLE;
            end
            if ((w_acc && !n_need_rd) || (r_state == ST_READ)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_pop_front <= n_pop_front;
            if (!n_need_rd) begin
                r_ok        <= n_ok;
                r_out_front <= out_val(n_empty, n_front);
                r_out_rear  <= out_val(n_empty, n_rear);
                r_out_empty <= n_empty;
                r_out_full  <= w_n_full;
            end
        end else if (r_state == ST_READ) begin
            r_front     <= w_rd_front;
            r_rear      <= w_rd_rear;
            r_ok        <= 1'b1;
            r_out_front <= out_val(r_empty, w_rd_front);
            r_out_rear  <= out_val(r_empty, w_rd_rear);
            r_out_empty <= r_empty;
            r_out_full  <= w_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_full, r_out_empty,
                            r_out_rear, r_out_front, r_ok};

endmodule

/* design/cdq_checker.sv */
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks for the circular deque
// Watches the result stream and the input handshake over time.
// ----------------------------------------------------------------------------
`include "circular_deque_assert.svh"

module cdq_checker
    import cdq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    `CDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")

    `CDQ_ASSERT_NOW(a_stall_blocks_in, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while result stalled")

    `CDQ_ASSERT_NOW(a_empty_result, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[M_EMPTY_BIT], !m_axis_tdata[M_FULL_BIT] && (m_axis_tdata[M_FRONT_LSB +: OUT_W] == m_axis_tdata[M_REAR_LSB +: OUT_W]), "empty result shows full or differing ends")

    `CDQ_ASSERT_NEXT(a_reset_drops, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
